/* rtl/smx_pkg.sv */
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and constants of the stack machine executor: command and
// status codes, sequencer states and the stack shift control.
// ----------------------------------------------------------------------------
package smx_pkg;

    // fixed field widths
    localparam int CMD_W     = 4;
    localparam int OPERAND_W = 32;
    localparam int STATUS_W  = 2;

    // parameter defaults
    localparam int STACK_DEPTH_DEF = 64;
    localparam int REG_COUNT_DEF   = 16;
    localparam int DATA_WIDTH_DEF  = 32;

    // instruction codes
    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN = 4'd0,
        CMD_END   = 4'd1,
        CMD_POP   = 4'd2,
        CMD_ADD   = 4'd3,
        CMD_SUB   = 4'd4,
        CMD_MUL   = 4'd5,
        CMD_DIV   = 4'd6,
        CMD_OUT   = 4'd7,
        CMD_IN    = 4'd8,
        CMD_PUSH  = 4'd9,
        CMD_PUSHR = 4'd10,
        CMD_POPR  = 4'd11
    } cmd_t;

    // completion codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_UNDER = 2'd1,
        STS_OVER  = 2'd2,
        STS_DIVZ  = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_DIV    = 2'd2,
        S_COMMIT = 2'd3
    } state_t;

    // shift control for the row of stack cells
    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctrl_t;

endpackage

/* rtl/stack_machine_executor.sv */
// Flow: an instruction is taken in S_IDLE, executed in S_EXEC and its result is
// registered on commit; a divide goes on through S_DIV and then S_COMMIT.
// No new instruction is taken before the last one commits, and commit waits
// for a free result slot; the iterative divider, one quotient bit per cycle, sets the long case.
// Reset: stack empty, register file cleared, running flag low; stack cells keep
// their contents, which are never read before being written.
// ----------------------------------------------------------------------------
// stack_machine_executor
// Runs one stack-machine instruction per transaction. The operand stack is a
// row of shifting cells with the top of stack in the first cell.
// ----------------------------------------------------------------------------
module stack_machine_executor #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
    parameter int REG_COUNT   = smx_pkg::REG_COUNT_DEF,
    parameter int DATA_WIDTH  = smx_pkg::DATA_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [smx_pkg::CMD_W-1:0]           s_cmd,
    input  logic [smx_pkg::OPERAND_W-1:0]       s_operand,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [smx_pkg::STATUS_W-1:0]        m_status,
    output logic [DATA_WIDTH-1:0]               m_out_value,
    output logic                                m_out_valid,
    output logic                                m_running,
    output logic [$clog2(STACK_DEPTH+1)-1:0]    m_depth
);

    localparam int  CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int  REG_IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int  DIV_W     = (DATA_WIDTH > smx_pkg::OPERAND_W) ? DATA_WIDTH
                                                                  : smx_pkg::OPERAND_W;
    localparam bit  REG_POW2  = ((REG_COUNT & (REG_COUNT - 1)) == 0);

    // reciprocal of the register count, exact for every operand value
    localparam int  RED_SH     = smx_pkg::OPERAND_W + REG_IDX_W;
    localparam int  RED_MUL_W  = smx_pkg::OPERAND_W + 1;
    localparam int  RED_PROD_W = smx_pkg::OPERAND_W + RED_MUL_W;
    localparam logic [RED_MUL_W-1:0] RED_MUL =
        RED_MUL_W'(((64'd1 << RED_SH) + 64'(REG_COUNT) - 64'd1) / 64'(REG_COUNT));

    smx_pkg::state_t                 state_reg, state_next;
    logic [smx_pkg::CMD_W-1:0]       cmd_reg;
    logic [smx_pkg::OPERAND_W-1:0]   operand_reg;
    logic [REG_IDX_W-1:0]            rf_idx_reg, rf_idx_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic                            running_reg, running_next;
    logic [DATA_WIDTH-1:0]           rf_reg [REG_COUNT];

    logic                            m_valid_reg, m_valid_next;
    smx_pkg::status_t                status_reg, status_next;
    logic [DATA_WIDTH-1:0]           out_value_reg, out_value_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            m_running_reg;
    logic [CNT_W-1:0]                m_depth_reg;

    smx_pkg::stk_ctrl_t              stk_ctrl;
    logic [DATA_WIDTH-1:0]           push_value;
    logic [DATA_WIDTH-1:0]           cell_data [STACK_DEPTH];
    logic [DATA_WIDTH-1:0]           top_a, next_b;

    logic                            out_free;
    logic                            late;
    logic                            commit;
    logic                            div_go;
    logic                            rf_we;
    logic [RED_PROD_W-1:0]           red_prod;
    logic [smx_pkg::OPERAND_W-1:0]   red_quo;
    logic [smx_pkg::OPERAND_W-1:0]   red_rem;
    logic [DIV_W-1:0]                div_dividend, div_divisor;
    logic                            div_busy, div_done;
    logic [DIV_W-1:0]                div_quo, div_rem;
    logic                            full, empty, under2;

    assign out_free = !m_valid_reg || m_ready;
    assign late     = (state_reg == smx_pkg::S_COMMIT);
    assign top_a    = cell_data[0];
    assign next_b   = cell_data[1];
    assign full     = (count_reg == CNT_W'(STACK_DEPTH));
    assign empty    = (count_reg == '0);
    assign under2   = (count_reg < CNT_W'(2));

    // register number: mask for a power-of-two file, else reciprocal multiply
    always_comb begin
        red_prod = RED_PROD_W'(s_operand) * RED_PROD_W'(RED_MUL);
        red_quo  = smx_pkg::OPERAND_W'(red_prod >> RED_SH);
        red_rem  = s_operand - red_quo * smx_pkg::OPERAND_W'(REG_COUNT);
        if (REG_POW2) begin
            rf_idx_next = REG_IDX_W'(s_operand & smx_pkg::OPERAND_W'(REG_COUNT - 1));
        end else begin
            rf_idx_next = REG_IDX_W'(red_rem);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            smx_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = smx_pkg::S_EXEC;
                end
            end
            smx_pkg::S_EXEC: begin
                if (div_go) begin
                    state_next = smx_pkg::S_DIV;
                end else if (out_free) begin
                    state_next = smx_pkg::S_IDLE;
                end
            end
            smx_pkg::S_DIV: begin
                if (div_done) begin
                    state_next = smx_pkg::S_COMMIT;
                end
            end
            smx_pkg::S_COMMIT: begin
                if (out_free) begin
                    state_next = smx_pkg::S_IDLE;
                end
            end
            default: state_next = smx_pkg::S_IDLE;
        endcase
    end

    // instruction decode and execution
    always_comb begin
        logic                  do_push;
        logic                  do_pop;
        logic                  need_div;
        logic [DATA_WIDTH-1:0] value;
        smx_pkg::status_t      sts;
        logic                  run;
        logic                  ovalid;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        need_div = 1'b0;
        value    = '0;
        sts      = smx_pkg::STS_OK;
        run      = running_reg;
        ovalid   = 1'b0;
        rf_we    = 1'b0;
        s_ready  = (state_reg == smx_pkg::S_IDLE);
        div_dividend = DIV_W'(top_a);
        div_divisor  = DIV_W'(next_b);

        case (smx_pkg::cmd_t'(cmd_reg))
            smx_pkg::CMD_BEGIN: run = 1'b1;
            smx_pkg::CMD_END:   run = 1'b0;
            smx_pkg::CMD_POP: begin
                if (empty) begin
                    sts = smx_pkg::STS_UNDER;
                end else begin
                    do_pop = 1'b1;
                end
            end
            smx_pkg::CMD_ADD, smx_pkg::CMD_SUB, smx_pkg::CMD_MUL: begin
                if (under2) begin
                    sts = smx_pkg::STS_UNDER;
                end else if (full) begin
                    sts = smx_pkg::STS_OVER;
                end else begin
                    do_push = 1'b1;
                    if (smx_pkg::cmd_t'(cmd_reg) == smx_pkg::CMD_ADD) begin
                        value = top_a + next_b;
                    end else if (smx_pkg::cmd_t'(cmd_reg) == smx_pkg::CMD_SUB) begin
                        value = top_a - next_b;
                    end else begin
                        value = top_a * next_b;
                    end
                end
            end
            smx_pkg::CMD_DIV: begin
                if (under2) begin
                    sts = smx_pkg::STS_UNDER;
                end else if (next_b == '0) begin
                    sts = smx_pkg::STS_DIVZ;
                end else if (full) begin
                    sts = smx_pkg::STS_OVER;
                end else begin
                    need_div = 1'b1;
                    do_push  = 1'b1;
                    value    = DATA_WIDTH'(div_quo);
                end
            end
            smx_pkg::CMD_OUT: begin
                if (empty) begin
                    sts = smx_pkg::STS_UNDER;
                end else begin
                    do_pop = 1'b1;
                    ovalid = 1'b1;
                end
            end
            smx_pkg::CMD_IN, smx_pkg::CMD_PUSH: begin
                if (full) begin
                    sts = smx_pkg::STS_OVER;
                end else begin
                    do_push = 1'b1;
                    value   = DATA_WIDTH'(operand_reg);
                end
            end
            smx_pkg::CMD_PUSHR: begin
                if (full) begin
                    sts = smx_pkg::STS_OVER;
                end else begin
                    do_push  = 1'b1;
                    value    = rf_reg[rf_idx_reg];
                end
            end
            smx_pkg::CMD_POPR: begin
                if (empty) begin
                    sts = smx_pkg::STS_UNDER;
                end else begin
                    do_pop   = 1'b1;
                    rf_we    = 1'b1;
                end
            end
            default: begin
            end
        endcase

        div_go = (state_reg == smx_pkg::S_EXEC) && need_div;
        commit = ((state_reg == smx_pkg::S_EXEC && !need_div) || late) && out_free;

        stk_ctrl.push = commit && do_push;
        stk_ctrl.pop  = commit && do_pop;
        rf_we         = commit && rf_we;
        push_value    = value;

        count_next   = count_reg;
        running_next = running_reg;
        if (commit) begin
            running_next = run;
            if (do_push) begin
                count_next = count_reg + CNT_W'(1);
            end else if (do_pop) begin
                count_next = count_reg - CNT_W'(1);
            end
        end

        status_next    = sts;
        out_valid_next = ovalid;
        out_value_next = ovalid ? top_a : '0;
        m_valid_next   = commit ? 1'b1 : (m_valid_reg && !m_ready);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= smx_pkg::S_IDLE;
            count_reg   <= '0;
            running_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            running_reg <= running_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // instruction capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg     <= s_cmd;
            operand_reg <= s_operand;
            rf_idx_reg  <= rf_idx_next;
        end
    end

    // register file, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                rf_reg[i] <= '0;
            end
        end else if (rf_we) begin
            rf_reg[rf_idx_reg] <= top_a;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (commit) begin
            status_reg    <= status_next;
            out_value_reg <= out_value_next;
            out_valid_reg <= out_valid_next;
            m_running_reg <= running_next;
            m_depth_reg   <= count_next;
        end
    end

    // row of stack cells, top of stack in cell 0
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] upper_d;
        logic [DATA_WIDTH-1:0] lower_d;
        if (g == 0) begin : g_first
            assign upper_d = push_value;
        end else begin : g_mid
            assign upper_d = cell_data[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_last
            assign lower_d = '0;
        end else begin : g_inner
            assign lower_d = cell_data[g+1];
        end
        smx_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (stk_ctrl),
            .upper_data (upper_d),
            .lower_data (lower_d),
            .data       (cell_data[g])
        );
    end

    // iterative divider
    smx_div #(
        .W (DIV_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_go),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_out_value = out_value_reg;
    assign m_out_valid = out_valid_reg;
    assign m_running   = m_running_reg;
    assign m_depth     = m_depth_reg;

    // stack count never passes the number of cells
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // a waiting result reports the current depth
    a_depth_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_depth_reg == count_reg)
        else $error("reported depth differs from stack count");

    // a delivered value only comes with a clean status
    a_out_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_valid_reg |-> status_reg == smx_pkg::STS_OK)
        else $error("out value with error status");

    // the divider only runs while the sequencer waits for it
    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> state_reg == smx_pkg::S_DIV)
        else $error("divider busy outside divide state");

    // an accepted transaction goes straight to execution
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == smx_pkg::S_EXEC)
        else $error("accepted transaction not executed");

endmodule

/* rtl/smx_cell.sv */
// ----------------------------------------------------------------------------
// smx_cell
// One stack entry. On push it takes the entry above it, on pop the entry
// below it, otherwise it holds.
// ----------------------------------------------------------------------------
module smx_cell #(
    parameter int DATA_WIDTH = smx_pkg::DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  smx_pkg::stk_ctrl_t    ctrl,
    input  logic [DATA_WIDTH-1:0] upper_data,
    input  logic [DATA_WIDTH-1:0] lower_data,
    output logic [DATA_WIDTH-1:0] data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // shift selection
    always_comb begin
        data_next = data_reg;
        if (ctrl.push) begin
            data_next = upper_data;
        end else if (ctrl.pop) begin
            data_next = lower_data;
        end
    end

    // entry storage, undefined until written
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* rtl/smx_div.sv */
// ----------------------------------------------------------------------------
// smx_div
// Restoring unsigned divider, one quotient bit per cycle. Used by the divide
// instruction.
// ----------------------------------------------------------------------------
module smx_div #(
    parameter int W = smx_pkg::OPERAND_W
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dsr_reg, dsr_next;
    logic [W:0]       trial;
    logic [W:0]       diff;

    // one restoring step
    always_comb begin
        trial     = {rem_reg, quo_reg[W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (diff[W]) begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end else begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* test/stack_machine_executor_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_executor_chk
// Watches both channels of the stack machine executor. It runs its own copy of
// the stack, registers and running flag for every accepted instruction, and
// compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module stack_machine_executor_chk #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
    parameter int REG_COUNT   = smx_pkg::REG_COUNT_DEF,
    parameter int DATA_WIDTH  = smx_pkg::DATA_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [smx_pkg::CMD_W-1:0]           s_cmd,
    input  logic [smx_pkg::OPERAND_W-1:0]       s_operand,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [smx_pkg::STATUS_W-1:0]        m_status,
    input  logic [DATA_WIDTH-1:0]               m_out_value,
    input  logic                                m_out_valid,
    input  logic                                m_running,
    input  logic [$clog2(STACK_DEPTH+1)-1:0]    m_depth,
    output int                                  fail_count,
    output int                                  outstanding
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    typedef struct packed {
        smx_pkg::status_t      status;
        logic [DATA_WIDTH-1:0] value;
        logic                  value_valid;
        logic                  running;
        logic [DEPTH_W-1:0]    depth;
    } result_t;

    // shadow machine state
    logic [DATA_WIDTH-1:0] shadow_stack [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] shadow_regs  [REG_COUNT];
    int                    stack_top;
    logic                  run_flag;

    result_t pending_results [$];
    int      mismatches;

    initial begin
        mismatches = 0;
        stack_top  = 0;
        run_flag   = 1'b0;
    end

    // push onto the shadow stack unless it is full
    function automatic smx_pkg::status_t push_word(logic [DATA_WIDTH-1:0] word);
        if (stack_top >= STACK_DEPTH)
            return smx_pkg::STS_OVER;
        shadow_stack[stack_top] = word;
        stack_top++;
        return smx_pkg::STS_OK;
    endfunction

    // run one instruction on the shadow state and give the result it should return
    function automatic result_t execute_instr(logic [smx_pkg::CMD_W-1:0] code,
                                              logic [smx_pkg::OPERAND_W-1:0] opnd);
        result_t               res;
        logic [DATA_WIDTH-1:0] top_word;
        logic [DATA_WIDTH-1:0] next_word;
        logic [DATA_WIDTH-1:0] calc;
        int                    reg_idx;

        res     = '0;
        res.status = smx_pkg::STS_OK;
        reg_idx = int'(opnd % REG_COUNT);
        case (code)
            smx_pkg::CMD_BEGIN: run_flag = 1'b1;
            smx_pkg::CMD_END:   run_flag = 1'b0;
            smx_pkg::CMD_POP: begin
                if (stack_top == 0)
                    res.status = smx_pkg::STS_UNDER;
                else
                    stack_top--;
            end
            smx_pkg::CMD_ADD, smx_pkg::CMD_SUB, smx_pkg::CMD_MUL, smx_pkg::CMD_DIV: begin
                if (stack_top < 2) begin
                    res.status = smx_pkg::STS_UNDER;
                end else begin
                    top_word  = shadow_stack[stack_top-1];
                    next_word = shadow_stack[stack_top-2];
                    // underflow, then zero divisor, then overflow
                    if (code == smx_pkg::CMD_DIV && next_word == '0) begin
                        res.status = smx_pkg::STS_DIVZ;
                    end else begin
                        case (code)
                            smx_pkg::CMD_ADD: calc = top_word + next_word;
                            smx_pkg::CMD_SUB: calc = top_word - next_word;
                            smx_pkg::CMD_MUL: calc = top_word * next_word;
                            default:          calc = top_word / next_word;
                        endcase
                        res.status = push_word(calc);
                    end
                end
            end
            smx_pkg::CMD_OUT: begin
                if (stack_top == 0) begin
                    res.status = smx_pkg::STS_UNDER;
                end else begin
                    stack_top--;
                    res.value       = shadow_stack[stack_top];
                    res.value_valid = 1'b1;
                end
            end
            smx_pkg::CMD_IN, smx_pkg::CMD_PUSH: res.status = push_word(DATA_WIDTH'(opnd));
            smx_pkg::CMD_PUSHR: res.status = push_word(shadow_regs[reg_idx]);
            smx_pkg::CMD_POPR: begin
                if (stack_top == 0) begin
                    res.status = smx_pkg::STS_UNDER;
                end else begin
                    stack_top--;
                    shadow_regs[reg_idx] = shadow_stack[stack_top];
                end
            end
            default: ;
        endcase
        res.running = run_flag;
        res.depth   = DEPTH_W'(stack_top);
        return res;
    endfunction

    // compare one field and report every difference
    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_v, act_v);
        end
    endtask

    // sample both channels on every rising edge
    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            stack_top = 0;
            run_flag  = 1'b0;
            foreach (shadow_regs[i])
                shadow_regs[i] = '0;
            pending_results.delete();
        end else begin
            // result transaction against the oldest prediction
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display({"%0t: result with nothing expected, expected none, ",
                              "actual status %0h value %0h"},
                             $time, m_status, m_out_value);
                end else begin
                    want = pending_results.pop_front();
                    check_field("status",    64'(want.status),      64'(m_status));
                    check_field("out_value", 64'(want.value),       64'(m_out_value));
                    check_field("out_valid", 64'(want.value_valid), 64'(m_out_valid));
                    check_field("running",   64'(want.running),     64'(m_running));
                    check_field("depth",     64'(want.depth),       64'(m_depth));
                end
            end
            // instruction transaction
            if (s_valid && s_ready)
                pending_results.push_back(execute_instr(s_cmd, s_operand));
        end
        outstanding <= pending_results.size();
        fail_count  <= mismatches;
    end

endmodule

/* test/stack_machine_executor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_executor_tb
// Drives the stack machine executor with a short directed program for underflow
// and division by zero, then a long random instruction stream that fills and
// drains the stack, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module stack_machine_executor_tb;

    localparam int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF;
    localparam int REG_COUNT   = smx_pkg::REG_COUNT_DEF;
    localparam int DATA_WIDTH  = smx_pkg::DATA_WIDTH_DEF;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int CMD_W       = smx_pkg::CMD_W;
    localparam int OPERAND_W   = smx_pkg::OPERAND_W;
    localparam int STATUS_W    = smx_pkg::STATUS_W;

    localparam int NUM_RANDOM  = 1700;
    localparam int TAIL_CYCLES = 80;
    localparam int TIMEOUT_NS  = 3_000_000;

    // unused command codes above the last real instruction
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = smx_pkg::CMD_POPR + 1'b1;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [CMD_W-1:0]       s_cmd     = '0;
    logic [OPERAND_W-1:0]   s_operand = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [STATUS_W-1:0]    m_status;
    logic [DATA_WIDTH-1:0]  m_out_value;
    logic                   m_out_valid;
    logic                   m_running;
    logic [DEPTH_W-1:0]     m_depth;

    int fail_count;
    int outstanding;
    int burst_left = 1;

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    stack_machine_executor #(
        .STACK_DEPTH (STACK_DEPTH),
        .REG_COUNT   (REG_COUNT),
        .DATA_WIDTH  (DATA_WIDTH)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_operand   (s_operand),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_out_value (m_out_value),
        .m_out_valid (m_out_valid),
        .m_running   (m_running),
        .m_depth     (m_depth)
    );

    stack_machine_executor_chk #(
        .STACK_DEPTH (STACK_DEPTH),
        .REG_COUNT   (REG_COUNT),
        .DATA_WIDTH  (DATA_WIDTH)
    ) result_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_operand   (s_operand),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_out_value (m_out_value),
        .m_out_valid (m_out_valid),
        .m_running   (m_running),
        .m_depth     (m_depth),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // receiver: stretches of open, coin-toss and sparse ready
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 2));
            rx_left <= $urandom_range(8, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:  m_ready <= 1'b1;
            RX_COIN:  m_ready <= 1'($urandom_range(0, 1));
            default:  m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // present one instruction and hold it until taken, with gaps between bursts
    task automatic send_instr(input logic [CMD_W-1:0] code,
                              input logic [OPERAND_W-1:0] opnd);
        int gap;
        s_valid   <= 1'b1;
        s_cmd     <= code;
        s_operand <= opnd;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 45)
                                              : $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 20);
        end
    endtask

    // hold off the sender until every result has come back
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    // instruction mix leaning towards filling, draining or neither
    function automatic logic [CMD_W-1:0] pick_cmd(mix_t mix);
        int unsigned roll;
        int unsigned p_push;
        int unsigned p_arith;
        int unsigned p_pop;
        logic [CMD_W-1:0] code;

        case (mix)
            MIX_FILL:  begin p_push = 55; p_arith = 25; p_pop = 12; end
            MIX_DRAIN: begin p_push = 15; p_arith = 15; p_pop = 62; end
            default:   begin p_push = 35; p_arith = 25; p_pop = 32; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < p_push) begin
            case ($urandom_range(0, 2))
                0:       code = smx_pkg::CMD_IN;
                1:       code = smx_pkg::CMD_PUSH;
                default: code = smx_pkg::CMD_PUSHR;
            endcase
        end else if (roll < p_push + p_arith) begin
            case ($urandom_range(0, 3))
                0:       code = smx_pkg::CMD_ADD;
                1:       code = smx_pkg::CMD_SUB;
                2:       code = smx_pkg::CMD_MUL;
                default: code = smx_pkg::CMD_DIV;
            endcase
        end else if (roll < p_push + p_arith + p_pop) begin
            case ($urandom_range(0, 2))
                0:       code = smx_pkg::CMD_POP;
                1:       code = smx_pkg::CMD_OUT;
                default: code = smx_pkg::CMD_POPR;
            endcase
        end else begin
            case ($urandom_range(0, 2))
                0:       code = smx_pkg::CMD_BEGIN;
                1:       code = smx_pkg::CMD_END;
                default: code = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            endcase
        end
        return code;
    endfunction

    // operands biased towards zero divisors and edge values
    function automatic logic [OPERAND_W-1:0] pick_operand();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)      return '0;
        else if (roll < 28) return OPERAND_W'(1);
        else if (roll < 34) return '1;
        else if (roll < 38) return {1'b1, {(OPERAND_W-1){1'b0}}};
        else if (roll < 55) return OPERAND_W'($urandom_range(0, 15));
        return $urandom();
    endfunction

    // stimulus and verdict
    initial begin
        mix_t mix;
        int   mix_left;

        mix      = MIX_BALANCED;
        mix_left = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: underflow on empty stack and with one entry
        send_instr(smx_pkg::CMD_POP,   '0);
        send_instr(smx_pkg::CMD_OUT,   '0);
        send_instr(smx_pkg::CMD_POPR,  32'd5);
        send_instr(smx_pkg::CMD_ADD,   '0);
        send_instr(smx_pkg::CMD_BEGIN, '0);
        send_instr(smx_pkg::CMD_PUSH,  32'hFFFF_FFFF);
        send_instr(smx_pkg::CMD_SUB,   '0);
        // register number wraps, never-written register reads zero
        send_instr(smx_pkg::CMD_PUSHR, 32'hFFFF_FFF3);
        send_instr(smx_pkg::CMD_DIV,   '0);
        // zero beneath the top gives division by zero
        send_instr(smx_pkg::CMD_PUSH,  32'd7);
        send_instr(smx_pkg::CMD_DIV,   '0);
        send_instr(smx_pkg::CMD_IN,    32'h8000_0000);
        send_instr(smx_pkg::CMD_ADD,   '0);
        send_instr(smx_pkg::CMD_MUL,   '0);
        send_instr(smx_pkg::CMD_SUB,   '0);
        send_instr(smx_pkg::CMD_DIV,   '0);
        send_instr(smx_pkg::CMD_OUT,   '0);
        send_instr(smx_pkg::CMD_POPR,  32'hFFFF_FFFF);
        send_instr(smx_pkg::CMD_PUSHR, 32'h0000_000F);
        // unused codes do nothing
        send_instr(CMD_SPARE_LO, 32'hA5A5_A5A5);
        send_instr(CMD_SPARE_HI, '1);
        send_instr(smx_pkg::CMD_END,   '0);
        send_instr(smx_pkg::CMD_PUSH,  '0);
        send_instr(smx_pkg::CMD_OUT,   '0);

        // random program in phases that fill, drain or mix
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (mix_left == 0) begin
                mix      = mix_t'($urandom_range(0, 2));
                mix_left = $urandom_range(20, 120);
            end
            mix_left--;
            if (n == NUM_RANDOM / 2)
                wait_results_drained();
            send_instr(pick_cmd(mix), pick_operand());
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
rtl/smx_pkg.sv
rtl/smx_cell.sv
rtl/smx_div.sv
rtl/stack_machine_executor.sv
test/stack_machine_executor_chk.sv
test/stack_machine_executor_tb.sv
